// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants for the text console character writer.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package tcw_pkg;

    localparam int FIELD_CURSOR_W = 11;
    localparam int CHAR_W         = 8;

    localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
    localparam logic [7:0] NULL_CHAR      = 8'h00;
    localparam logic [7:0] BLANK_CHAR     = 8'h20;
    localparam logic [7:0] ATTR_RESET     = 8'h0A;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic put;
        logic rd_start;
        logic rd_finish;
        logic copy;
        logic fill;
        logic clear;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic put_scrolls;
        logic sweep_end;
        logic copy_end;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_in_if.sv =====
// Input channel of the text console character writer: put and read requests.
// Depends on tcw_pkg for the field widths.
`default_nettype none

interface tcw_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [tcw_pkg::CHAR_W-1:0]  character;
    logic [10:0]                 read_cell;

    modport source (output valid, output command, output character, output read_cell,
                    input ready);
    modport sink (input valid, input command, input character, input read_cell,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcw_out_if.sv =====
// Result channel of the text console character writer.
// Depends on tcw_pkg for the field widths.
`default_nettype none

interface tcw_out_if;
    logic                                valid;
    logic                                ready;
    logic [tcw_pkg::FIELD_CURSOR_W-1:0]  cursor_position;
    logic                                scrolled;
    logic [tcw_pkg::CHAR_W-1:0]          cell_character;
    logic [tcw_pkg::CHAR_W-1:0]          cell_attribute;

    modport source (output valid, output cursor_position, output scrolled,
                    output cell_character, output cell_attribute, input ready);
    modport sink (input valid, input cursor_position, input scrolled,
                  input cell_character, input cell_attribute, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine of the text console character writer.
// Depends on tcw_pkg for the command and status structs.
`default_nettype none

module tcw_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_command,
    output logic                  o_in_ready,
    input  wire tcw_pkg::t_dp_sts i_sts,
    output tcw_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_COPY  = 5'b01000,
        S_FILL  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.sweep_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_command == tcw_pkg::CMD_READ) begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_READ;
                    end else begin
                        o_cmd.put = 1'b1;
                        if (i_sts.put_scrolls) begin
                            n_state = S_COPY;
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_finish = 1'b1;
                n_state         = S_IDLE;
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.copy_end) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.sweep_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_dp.sv =====
// Datapath of the text console character writer: screen memory, cursor,
// sweep counter, attribute register and result register.
// Depends on tcw_pkg for constants and the command and status structs.
`default_nettype none

module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [7:0]                          i_cfg_wr_data,
    input  wire logic                                i_command,
    input  wire logic [7:0]                          i_character,
    input  wire logic [10:0]                         i_read_cell,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [tcw_pkg::FIELD_CURSOR_W-1:0]       o_cursor_position,
    output logic                                     o_scrolled,
    output logic [7:0]                               o_cell_character,
    output logic [7:0]                               o_cell_attribute,
    input  wire tcw_pkg::t_dp_cmd                    i_cmd,
    output tcw_pkg::t_dp_sts                         o_sts
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(COLUMNS);
    localparam int LAST_ROW = CELLS - COLUMNS;

    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rdata;
    logic          r_rd_oor;

    logic [7:0]    r_attr;
    logic [AW-1:0] r_cursor;
    logic [AW-1:0] n_cursor;
    logic [AW-1:0] r_row_base;
    logic [AW-1:0] n_row_base;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [AW-1:0] r_sweep;
    logic [AW-1:0] n_sweep;

    logic                               r_out_valid;
    logic [tcw_pkg::FIELD_CURSOR_W-1:0] r_out_cursor;
    logic                               r_out_scrolled;
    logic [7:0]                         r_out_char;
    logic [7:0]                         r_out_attr;

    logic          w_is_nl;
    logic          w_is_null;
    logic          w_put_scrolls;
    logic          w_sweep_end;
    logic          w_copy_end;
    logic [31:0]   w_rc32;
    logic          w_rc_oor;
    logic [31:0]   w_ncur32;
    logic [31:0]   w_rcur32;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;

    assign w_is_nl     = (i_character == tcw_pkg::NEWLINE_CHAR);
    assign w_is_null   = (i_character == tcw_pkg::NULL_CHAR);
    assign w_sweep_end = (r_sweep == AW'(CELLS - 1));
    assign w_copy_end  = (r_sweep == AW'(LAST_ROW));
    assign w_rc32      = 32'(i_read_cell);
    assign w_rc_oor    = (w_rc32 >= 32'(CELLS));

    // A put scrolls when the cursor would land one past the last cell.
    assign w_put_scrolls = (i_command == tcw_pkg::CMD_PUT) &&
                           ((w_is_nl && (r_row_base == AW'(LAST_ROW))) ||
                            (!w_is_nl && !w_is_null && (r_cursor == AW'(CELLS - 1))));

    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.put_scrolls = w_put_scrolls;
    assign o_sts.sweep_end   = w_sweep_end;
    assign o_sts.copy_end    = w_copy_end;

    // Cursor update for a put.
    always_comb begin
        n_cursor   = r_cursor;
        n_row_base = r_row_base;
        n_col      = r_col;
        if (i_cmd.put && !w_is_null) begin
            if (w_put_scrolls) begin
                n_cursor   = AW'(LAST_ROW);
                n_row_base = AW'(LAST_ROW);
                n_col      = '0;
            end else if (w_is_nl) begin
                n_cursor   = r_row_base + AW'(COLUMNS);
                n_row_base = r_row_base + AW'(COLUMNS);
                n_col      = '0;
            end else begin
                n_cursor = r_cursor + AW'(1);
                if (r_col == CW'(COLUMNS - 1)) begin
                    n_col      = '0;
                    n_row_base = r_row_base + AW'(COLUMNS);
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end
    end

    // Sweep counter for clearing, copying rows up and blanking the bottom row.
    always_comb begin
        n_sweep = r_sweep;
        if (i_cmd.put) begin
            n_sweep = '0;
        end else if (i_cmd.clear || i_cmd.fill) begin
            n_sweep = w_sweep_end ? '0 : r_sweep + AW'(1);
        end else if (i_cmd.copy && !w_copy_end) begin
            n_sweep = r_sweep + AW'(1);
        end
    end

    // Memory port selection. The copy reads one row ahead and writes the word
    // read in the previous cycle one address behind the sweep counter.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cursor;
        w_wdata = {r_attr, i_character};
        w_re    = 1'b0;
        w_raddr = w_rc32[AW-1:0];
        if (i_cmd.clear) begin
            w_we    = 1'b1;
            w_waddr = r_sweep;
            w_wdata = '0;
        end else if (i_cmd.fill) begin
            w_we    = 1'b1;
            w_waddr = r_sweep;
            w_wdata = {r_attr, tcw_pkg::BLANK_CHAR};
        end else if (i_cmd.copy) begin
            w_we    = (r_sweep != '0);
            w_waddr = r_sweep - AW'(1);
            w_wdata = r_rdata;
            w_re    = !w_copy_end;
            w_raddr = r_sweep + AW'(COLUMNS);
        end else if (i_cmd.put) begin
            w_we = !w_is_nl && !w_is_null;
        end else if (i_cmd.rd_start) begin
            w_re = !w_rc_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
        if (i_cmd.rd_start) begin
            r_rd_oor <= w_rc_oor;
        end
    end

    assign w_ncur32 = 32'(n_cursor);
    assign w_rcur32 = 32'(r_cursor);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.put && !w_put_scrolls) begin
            r_out_cursor   <= w_ncur32[tcw_pkg::FIELD_CURSOR_W-1:0];
            r_out_scrolled <= 1'b0;
            r_out_char     <= '0;
            r_out_attr     <= '0;
        end else if (i_cmd.fill && w_sweep_end) begin
            r_out_cursor   <= w_rcur32[tcw_pkg::FIELD_CURSOR_W-1:0];
            r_out_scrolled <= 1'b1;
            r_out_char     <= '0;
            r_out_attr     <= '0;
        end else if (i_cmd.rd_finish) begin
            r_out_cursor   <= w_rcur32[tcw_pkg::FIELD_CURSOR_W-1:0];
            r_out_scrolled <= 1'b0;
            r_out_char     <= r_rd_oor ? 8'h00 : r_rdata[7:0];
            r_out_attr     <= r_rd_oor ? 8'h00 : r_rdata[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_cursor    <= '0;
            r_row_base  <= '0;
            r_col       <= '0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            r_cursor   <= n_cursor;
            r_row_base <= n_row_base;
            r_col      <= n_col;
            r_sweep    <= n_sweep;
            if ((i_cmd.put && !w_put_scrolls) || (i_cmd.fill && w_sweep_end) ||
                i_cmd.rd_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_cursor;
    assign o_scrolled        = r_out_scrolled;
    assign o_cell_character  = r_out_char;
    assign o_cell_attribute  = r_out_attr;

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_char_writer.sv =====
// Top level of the text console character writer: controller plus datapath.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_ctrl and tcw_dp.
//
//   Port         Dir  Handshake       Carries
//   i_in         in   valid/ready     command, character, read_cell
//   o_out        out  valid/ready     cursor_position, scrolled, cell_character,
//                                     cell_attribute
//   i_cfg_wr_*   in   write enable    text_attribute
//
// A read passes through a second controller state, S_READ, for the registered
// memory read. A scrolling put holds off input while the single-port-write
// screen memory is copied up one row and the bottom row is blanked. After reset
// a clearing pass zeroes the screen before the first transaction is taken. A
// waiting result in the output register blocks only the next acceptance.
`default_nettype none

module text_console_char_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    tcw_in_if.sink          i_in,
    tcw_out_if.source       o_out
);

    localparam int LAST_ROW = (ROWS - 1) * COLUMNS;

    tcw_pkg::t_dp_cmd w_cmd;
    tcw_pkg::t_dp_sts w_sts;

    tcw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .o_in_ready   (i_in.ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_command         (i_in.command),
        .i_character       (i_in.character),
        .i_read_cell       (i_in.read_cell),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_cursor_position (o_out.cursor_position),
        .o_scrolled        (o_out.scrolled),
        .o_cell_character  (o_out.cell_character),
        .o_cell_attribute  (o_out.cell_attribute),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.put, w_cmd.rd_start, w_cmd.rd_finish, w_cmd.copy,
                  w_cmd.fill, w_cmd.clear}))
        else $error("More than one datapath command active.");

    a_read_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_start |=> w_cmd.rd_finish)
        else $error("Read did not finish in the following cycle.");

    a_scroll_defers_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.put && w_sts.put_scrolls |=> !o_out.valid && w_cmd.copy)
        else $error("Scrolling put did not start the row copy.");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.scrolled |->
            o_out.cursor_position == tcw_pkg::FIELD_CURSOR_W'(LAST_ROW))
        else $error("Scrolled result does not report the bottom row start.");

endmodule

`default_nettype wire
